[sv/rsbt_pkg.sv]
`default_nettype none

package rsbt_pkg;

  // Field widths of one stored record.
  localparam int unsigned MinutesW = 11;
  localparam int unsigned NumberW  = 16;
  localparam int unsigned TagW     = 8;

  // One record as it sits in the store.
  typedef struct packed {
    logic [MinutesW-1:0] minutes;
    logic [NumberW-1:0]  number;
    logic [TagW-1:0]     tag;
  } rec_t;

  // Control from the sequencer to the minimum search unit.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

endpackage

`default_nettype wire

[sv/rsbt_min_scan.sv]
`default_nettype none

module rsbt_min_scan #(
  parameter int unsigned IDX_W = 4
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire rsbt_pkg::scan_ctrl_t ctrl_i,
  input  wire rsbt_pkg::rec_t rec_i,
  input  wire [IDX_W-1:0]     idx_i,
  input  wire                 skip_i,
  output rsbt_pkg::rec_t      best_o,
  output logic [IDX_W-1:0]    best_idx_o
);
  import rsbt_pkg::*;

  logic             have_q;
  rec_t             best_q;
  logic [IDX_W-1:0] best_idx_q;
  logic             take;

  // Strict less-than keeps the earliest of equal keys, which makes the order stable.
  assign take = ctrl_i.sample && !skip_i &&
                (!have_q || (rec_i.minutes < best_q.minutes));

  // Running minimum over the records presented during one scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  // The winning record itself needs no reset.
  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q     <= rec_i;
      best_idx_q <= idx_i;
    end
  end

  assign best_o     = best_q;
  assign best_idx_o = best_idx_q;

endmodule

`default_nettype wire

[sv/record_sort_by_time_key.sv]
`default_nettype none

// Stable ascending sort of a record set by departure time.
// A request is taken at a rising edge with start_i high and busy_o low.
// Each request carries one record; it is stored while fewer than MAX_RECORDS
// records are held, and dropped otherwise (the set is then flagged overflow).
// A request with last_record_i high closes the set and starts the output run.
// Records load at one per cycle. After the closing request the block
// is busy while it emits the n stored records: each result is found by one
// scan of the record memory through a single key comparator, followed by a
// drain step and an emit step.
// Each result is on the sorted_* ports for one cycle with result_strobe_o
// high; the receiver cannot stall the block. last_out_o marks the final
// result and overflow_o reports dropped records on every result of the set.
// Reset empties the set; the record memory holds no reset value and only
// entries written in the current set are read.

module record_sort_by_time_key #(
  parameter int unsigned MAX_RECORDS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire  [10:0] departure_minutes_i,
  input  wire  [15:0] train_number_i,
  input  wire  [7:0]  record_tag_i,
  input  wire         last_record_i,
  output logic        result_strobe_o,
  output logic [10:0] sorted_minutes_o,
  output logic [15:0] sorted_number_o,
  output logic [7:0]  sorted_tag_o,
  output logic        last_out_o,
  output logic        overflow_o
);
  import rsbt_pkg::*;

  localparam int unsigned IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   out_cnt_q;
  logic              dropped_q;
  logic [IdxW-1:0]   rd_addr_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              sample_q;
  logic [MAX_RECORDS-1:0] emitted_q;

  rec_t              mem [MAX_RECORDS];
  rec_t              rd_data_q;
  rec_t              in_rec;
  rec_t              best;
  logic [IdxW-1:0]   best_idx;
  scan_ctrl_t        scan_ctrl;

  logic              accept;
  logic              store_ok;
  logic              last_addr;
  logic              last_result;

  assign busy_o   = (state_q != ST_IDLE);
  assign accept   = start_i && !busy_o;
  assign store_ok = (count_q < CntW'(MAX_RECORDS));

  assign in_rec.minutes = departure_minutes_i;
  assign in_rec.number  = train_number_i;
  assign in_rec.tag     = record_tag_i;

  assign last_addr   = ((CntW'(rd_addr_q) + CntW'(1)) == count_q);
  assign last_result = ((out_cnt_q + CntW'(1)) == count_q);

  // Record memory: one write port for loading, one registered read port for scans.
  always_ff @(posedge clk_i) begin
    if (accept && store_ok) begin
      mem[count_q[IdxW-1:0]] <= in_rec;
    end
    rd_data_q <= mem[rd_addr_q];
    rd_idx_q  <= rd_addr_q;
  end

  // The compare unit sees each read in the cycle after its address goes out.
  assign scan_ctrl.clear  = (state_q == ST_EMIT);
  assign scan_ctrl.sample = sample_q;

  rsbt_min_scan #(
    .IDX_W (IdxW)
  ) u_min_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (scan_ctrl),
    .rec_i      (rd_data_q),
    .idx_i      (rd_idx_q),
    .skip_i     (emitted_q[rd_idx_q]),
    .best_o     (best),
    .best_idx_o (best_idx)
  );

  // Sequencer: load records, then one scan and one result per stored record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      count_q         <= '0;
      out_cnt_q       <= '0;
      dropped_q       <= 1'b0;
      rd_addr_q       <= '0;
      sample_q        <= 1'b0;
      emitted_q       <= '0;
      result_strobe_o <= 1'b0;
      last_out_o      <= 1'b0;
      overflow_o      <= 1'b0;
    end else begin
      result_strobe_o <= 1'b0;
      sample_q        <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (store_ok) begin
              count_q <= count_q + CntW'(1);
            end else begin
              dropped_q <= 1'b1;
            end
            if (last_record_i) begin
              rd_addr_q <= '0;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          sample_q <= 1'b1;
          if (last_addr) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_addr_q <= rd_addr_q + IdxW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          result_strobe_o <= 1'b1;
          last_out_o      <= last_result;
          overflow_o      <= dropped_q;
          rd_addr_q       <= '0;
          if (last_result) begin
            count_q   <= '0;
            out_cnt_q <= '0;
            dropped_q <= 1'b0;
            emitted_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            out_cnt_q           <= out_cnt_q + CntW'(1);
            emitted_q[best_idx] <= 1'b1;
            state_q             <= ST_SCAN;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload follows the winner of the finished scan.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      sorted_minutes_o <= best.minutes;
      sorted_number_o  <= best.number;
      sorted_tag_o     <= best.tag;
    end
  end

endmodule

`default_nettype wire

[tb/record_sort_by_time_key_test.sv]
module record_sort_by_time_key_test;
  import rsbt_pkg::*;

  localparam int unsigned MaxRecords = 16;
  // Bound on the longest output run of one set, for a full store.
  localparam int unsigned RunCycles = MaxRecords * (MaxRecords + 2);
  localparam int unsigned RandomRequests = 210;
  // Idle bursts on the request side stop after this many random requests.
  localparam int unsigned IdleFreeFrom = 170;

  // One expected result of a sorted run.
  typedef struct {
    rec_t rec;
    logic is_final;
    logic flagged;
  } sorted_entry_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [10:0] departure_minutes;
  logic [15:0] train_number;
  logic [7:0]  record_tag;
  logic        last_record;
  logic        result_strobe;
  logic [10:0] sorted_minutes;
  logic [15:0] sorted_number;
  logic [7:0]  sorted_tag;
  logic        last_out;
  logic        overflow;

  // Predictor state: records held in the open set and its overflow mark.
  rec_t          held_records[$];
  bit            set_overflowed;
  sorted_entry_t sorted_expect_q[$];
  int            mismatch_count;
  bit            gaps_on;

  record_sort_by_time_key #(
    .MAX_RECORDS(MaxRecords)
  ) uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .start_i            (start),
    .busy_o             (busy),
    .departure_minutes_i(departure_minutes),
    .train_number_i     (train_number),
    .record_tag_i       (record_tag),
    .last_record_i      (last_record),
    .result_strobe_o    (result_strobe),
    .sorted_minutes_o   (sorted_minutes),
    .sorted_number_o    (sorted_number),
    .sorted_tag_o       (sorted_tag),
    .last_out_o         (last_out),
    .overflow_o         (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off here if results stop coming.
  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

  // Store the record of an accepted request; a closing request yields the set
  // in stable ascending key order.
  function automatic void predict_load(rec_t r, logic closes);
    rec_t ordered[$];
    rec_t moving;
    int   j;
    if (held_records.size() < MaxRecords) begin
      held_records.push_back(r);
    end else begin
      set_overflowed = 1'b1;
    end
    if (!closes) return;
    ordered = held_records;
    // Insertion sort with a strict compare keeps equal keys in arrival order.
    for (int i = 1; i < ordered.size(); i++) begin
      moving = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1].minutes > moving.minutes) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = moving;
    end
    foreach (ordered[k]) begin
      sorted_expect_q.push_back('{rec: ordered[k], is_final: (k == ordered.size() - 1),
                                  flagged: set_overflowed});
    end
    held_records.delete();
    set_overflowed = 1'b0;
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic request_record(input logic [10:0] minutes, input logic [15:0] number,
                                input logic [7:0] tag, input logic closes);
    rec_t r;
    @(negedge clk);
    start             = 1'b1;
    departure_minutes = minutes;
    train_number      = number;
    record_tag        = tag;
    last_record       = closes;
    do @(posedge clk); while (busy);
    r.minutes = minutes;
    r.number  = number;
    r.tag     = tag;
    predict_load(r, closes);
  endtask

  // Drop the request line for a random burst, with junk on the record ports.
  task automatic maybe_idle();
    int cycles;
    if (!gaps_on || $urandom_range(0, 2) != 0) return;
    cycles = $urandom_range(1, 9);
    @(negedge clk);
    start             = 1'b0;
    departure_minutes = 11'($urandom);
    train_number      = 16'($urandom);
    record_tag        = 8'($urandom);
    last_record       = 1'($urandom);
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] expected_v,
                             input logic [15:0] actual_v);
    if (actual_v !== expected_v) begin
      $error("%s: expected %0h, actual %0h", name, expected_v, actual_v);
      mismatch_count++;
    end
  endtask

  // Compare every strobed result with the oldest expected one.
  always @(posedge clk) begin
    sorted_entry_t want;
    if (rst_n && result_strobe === 1'b1) begin
      if (sorted_expect_q.size() == 0) begin
        $error("result with none expected: sorted_minutes %0d, sorted_tag %0h",
               sorted_minutes, sorted_tag);
        mismatch_count++;
      end else begin
        want = sorted_expect_q.pop_front();
        check_field("sorted_minutes", 16'(want.rec.minutes), 16'(sorted_minutes));
        check_field("sorted_number", want.rec.number, sorted_number);
        check_field("sorted_tag", 16'(want.rec.tag), 16'(sorted_tag));
        check_field("last_out", 16'(want.is_final), 16'(last_out));
        check_field("overflow", 16'(want.flagged), 16'(overflow));
      end
    end
  end

  // A set of one record, every field at its all-ones value, key past the day.
  task automatic test_single_record();
    request_record(11'd2047, 16'hFFFF, 8'hFF, 1'b1);
  endtask

  // Keys at both ends of the day and beyond it, with repeated keys for order.
  task automatic test_mixed_keys();
    request_record(11'd1439, 16'h0000, 8'h00, 1'b0);
    request_record(11'd0,    16'hA5A5, 8'h01, 1'b0);
    request_record(11'd2047, 16'h5A5A, 8'h02, 1'b0);
    request_record(11'd1440, 16'h1234, 8'h03, 1'b0);
    request_record(11'd0,    16'hFFFF, 8'h04, 1'b0);
    request_record(11'd1439, 16'h0001, 8'h05, 1'b1);
  endtask

  // Fill the store in descending key order; the closing request is dropped.
  task automatic test_overflow_set();
    for (int i = 0; i < MaxRecords; i++) begin
      maybe_idle();
      request_record(11'(1439 - i * 90), 16'(i * 4099), 8'(i), 1'b0);
    end
    request_record(11'd0, 16'hBEEF, 8'hEE, 1'b1);
  endtask

  // Random sets: mostly small, some filling or overrunning the store.
  task automatic test_random_sets();
    int sent;
    int set_size;
    int key_mode;
    logic [10:0] key;
    sent = 0;
    while (sent < RandomRequests) begin
      case ($urandom_range(0, 9))
        0: begin
          set_size = $urandom_range(MaxRecords - 2, MaxRecords + 4);
        end
        1: begin
          set_size = MaxRecords;
        end
        default: begin
          set_size = $urandom_range(1, 8);
        end
      endcase
      key_mode = $urandom_range(0, 2);
      gaps_on  = (sent < IdleFreeFrom) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < set_size; i++) begin
        case (key_mode)
          0: begin
            key = 11'($urandom);
          end
          1: begin
            key = 11'($urandom_range(0, 1439));
          end
          default: begin
            // Few distinct keys, so ties are common.
            key = 11'($urandom_range(0, 3) * 480);
          end
        endcase
        maybe_idle();
        request_record(key, 16'($urandom), 8'($urandom), i == set_size - 1);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    departure_minutes = '0;
    train_number      = '0;
    record_tag        = '0;
    last_record       = 1'b0;
    set_overflowed    = 1'b0;
    mismatch_count    = 0;
    gaps_on           = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_record();
    test_mixed_keys();
    test_overflow_set();
    test_random_sets();

    @(negedge clk);
    start = 1'b0;
    while (sorted_expect_q.size() != 0) @(posedge clk);
    // Watch for stray results after the last run.
    repeat (RunCycles + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
